// ===== design/lsft_pkg.sv =====
// Shared types, constants and helpers for the learning switch forwarding table.
// No dependencies; the interfaces, the core and the compare unit use this package.
`timescale 1ns / 1ps

package lsft_pkg;

  localparam int PortW    = 4;
  localparam int AddrW    = 16;
  localparam int MaskW    = 16;
  localparam int NumPorts = 16;
  localparam int TableDepthDef = 32;

  typedef logic [PortW-1:0] port_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [MaskW-1:0] mask_t;

  localparam addr_t BcastAddr = '1;

  // Ports that exist; output mask is clipped to MaskW bits.
  localparam mask_t AllPortsMask = (NumPorts >= MaskW) ? '1 :
                                   MaskW'((64'd1 << NumPorts) - 64'd1);

  function automatic mask_t port_bit(port_t p);
    mask_t m;
    m = mask_t'(1) << p;
    return m & AllPortsMask;
  endfunction

  function automatic mask_t flood_mask(port_t ingress);
    mask_t m;
    m = mask_t'(1) << ingress;
    return AllPortsMask & ~m;
  endfunction

endpackage

// ===== design/lsft_if.sv =====
// Channel interfaces: frame header words in, forwarding result words out.
// Depends on lsft_pkg for payload types.
`timescale 1ns / 1ps

interface lsft_in_if;
  logic            valid;
  logic            ready;
  lsft_pkg::port_t ingress_port;
  lsft_pkg::addr_t dest_address;
  lsft_pkg::addr_t src_address;

  modport source (output valid, output ingress_port, output dest_address,
                  output src_address, input ready);
  modport sink   (input valid, input ingress_port, input dest_address,
                  input src_address, output ready);
endinterface

interface lsft_out_if;
  logic            valid;
  logic            ready;
  lsft_pkg::mask_t forward_mask;
  logic            learn_dropped;

  modport source (output valid, output forward_mask, output learn_dropped,
                  input ready);
  modport sink   (input valid, input forward_mask, input learn_dropped,
                  output ready);
endinterface

// ===== design/learning_switch_forward_table_core.sv =====
// Top level of the learning switch forwarding table: sequencer, table RAM,
// compare unit. Depends on lsft_pkg, lsft_if, lsft_ram, lsft_match.
`timescale 1ns / 1ps

//  channel    dir  word                                         handshake
//  frame_i    in   ingress_port, dest_address, src_address       valid/ready
//  result_o   out  forward_mask, learn_dropped                   valid/ready
//
//  A broadcast word skips the table scan and learning. Any other word scans
//  the N learned entries (N at most TableDepth): the table RAM's single read
//  port hands one entry per cycle to the compare unit, and the last read data
//  is compared before the table is updated.
//  Reset clears the fill count, not the entries; learning writes the lowest
//  free slot and never removes, so the occupied slots are always 0..N-1.
//  One result register sits at the output: a finished word waits there
//  while the next frame header is taken in.

module learning_switch_forward_table_core #(
  parameter int TableDepth = lsft_pkg::TableDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsft_in_if.sink    frame_i,
  lsft_out_if.source result_o
);
  import lsft_pkg::*;

  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int EntW = AddrW + PortW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  port_t           ingress_q, ingress_d;
  addr_t           dest_q, dest_d;
  addr_t           src_q, src_d;
  logic [CntW-1:0] ctr_q, ctr_d;       // next entry to read
  logic [CntW-1:0] count_q, count_d;   // entries learned so far
  logic            pend_q, pend_d;     // read data arrives this cycle
  logic [IdxW-1:0] pidx_q, pidx_d;
  mask_t           mask_q, mask_d;
  logic            drop_q, drop_d;
  logic            out_valid_q, out_valid_d;
  mask_t           out_mask_q, out_mask_d;
  logic            out_drop_q, out_drop_d;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  logic [EntW-1:0] ram_rdata;
  logic            match_clear;
  logic            src_hit, dest_hit;
  logic [IdxW-1:0] src_idx;
  port_t           hit_port;
  logic            table_full, self_hit;

  lsft_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({src_q, ingress_q}),
    .re_i    (ram_re),
    .raddr_i (ctr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  lsft_match #(
    .TableDepth (TableDepth)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (match_clear),
    .valid_i      (pend_q),
    .idx_i        (pidx_q),
    .entry_addr_i (ram_rdata[EntW-1:PortW]),
    .entry_port_i (ram_rdata[PortW-1:0]),
    .src_i        (src_q),
    .dest_i       (dest_q),
    .src_hit_o    (src_hit),
    .src_idx_o    (src_idx),
    .dest_hit_o   (dest_hit),
    .hit_port_o   (hit_port)
  );

  assign frame_i.ready          = (state_q == ST_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.forward_mask  = out_mask_q;
  assign result_o.learn_dropped = out_drop_q;

  assign table_full = (count_q == CntW'(TableDepth));
  // Learning runs before lookup: dest == src hits the just-learned entry
  // unless the source could not be stored.
  assign self_hit   = (dest_q == src_q) && (src_hit || !table_full);

  always_comb begin
    state_d     = state_q;
    ingress_d   = ingress_q;
    dest_d      = dest_q;
    src_d       = src_q;
    ctr_d       = ctr_q;
    count_d     = count_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    mask_d      = mask_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_drop_d  = out_drop_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = count_q[IdxW-1:0];
    match_clear = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (frame_i.valid) begin
          ingress_d = frame_i.ingress_port;
          dest_d    = frame_i.dest_address;
          src_d     = frame_i.src_address;
          if (frame_i.dest_address == BcastAddr) begin
            // Broadcast: flood, no learning.
            mask_d  = flood_mask(frame_i.ingress_port);
            drop_d  = 1'b0;
            state_d = ST_DONE;
          end else begin
            ctr_d       = '0;
            pend_d      = 1'b0;
            match_clear = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ctr_q < count_q) begin
          ram_re = 1'b1;
          ctr_d  = ctr_q + CntW'(1);
          pend_d = 1'b1;
          pidx_d = ctr_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        drop_d = 1'b0;
        if (src_hit) begin
          ram_we    = 1'b1;
          ram_waddr = src_idx;
        end else if (!table_full) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
        end else begin
          drop_d = 1'b1;
        end
        if (self_hit) begin
          mask_d = port_bit(ingress_q);
        end else if (dest_hit) begin
          mask_d = port_bit(hit_port);
        end else begin
          mask_d = flood_mask(ingress_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_mask_d  = mask_q;
          out_drop_d  = drop_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ingress_q  <= ingress_d;
    dest_q     <= dest_d;
    src_q      <= src_d;
    pidx_q     <= pidx_d;
    mask_q     <= mask_d;
    drop_q     <= drop_d;
    out_mask_q <= out_mask_d;
    out_drop_q <= out_drop_d;
  end

endmodule

// ===== design/lsft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsft_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lsft_match.sv =====
// Shared compare unit: checks one table entry per cycle against the source
// and destination keys and keeps the hit index / port. Depends on lsft_pkg.
`timescale 1ns / 1ps

module lsft_match #(
  parameter int TableDepth = lsft_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          valid_i,
  input  logic [$clog2(TableDepth)-1:0] idx_i,
  input  lsft_pkg::addr_t               entry_addr_i,
  input  lsft_pkg::port_t               entry_port_i,
  input  lsft_pkg::addr_t               src_i,
  input  lsft_pkg::addr_t               dest_i,
  output logic                          src_hit_o,
  output logic [$clog2(TableDepth)-1:0] src_idx_o,
  output logic                          dest_hit_o,
  output lsft_pkg::port_t               hit_port_o
);
  import lsft_pkg::*;

  localparam int IdxW = $clog2(TableDepth);

  logic            src_hit_q, dest_hit_q;
  logic [IdxW-1:0] src_idx_q;
  port_t           hit_port_q;
  logic            src_eq, dest_eq;

  assign src_eq  = valid_i && (entry_addr_i == src_i);
  assign dest_eq = valid_i && (entry_addr_i == dest_i);

  // Stored addresses are unique, so at most one entry matches each key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_hit_q  <= 1'b0;
      dest_hit_q <= 1'b0;
    end else if (clear_i) begin
      src_hit_q  <= 1'b0;
      dest_hit_q <= 1'b0;
    end else begin
      if (src_eq)  src_hit_q  <= 1'b1;
      if (dest_eq) dest_hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_eq)  src_idx_q  <= idx_i;
    if (dest_eq) hit_port_q <= entry_port_i;
  end

  assign src_hit_o  = src_hit_q;
  assign src_idx_o  = src_idx_q;
  assign dest_hit_o = dest_hit_q;
  assign hit_port_o = hit_port_q;

endmodule
